// ===== src/sbcb_pkg.sv =====
`timescale 1ns / 1ps
package sbcb_pkg;

    // Width of the scaled dividend: (offset * baseline + 8 * disparity) >> 4.
    localparam int DVD_W = 37;

    localparam logic [1:0] CFG_BASELINE = 2'd0;
    localparam logic [1:0] CFG_FOCAL    = 2'd1;
    localparam logic [1:0] CFG_CENTER_U = 2'd2;
    localparam logic [1:0] CFG_CENTER_V = 2'd3;

    // One axis in flight through the divider chain.
    typedef struct packed {
        logic             neg;
        logic [7:0]       disp;
        logic [7:0]       rem;
        logic [DVD_W-1:0] dvd;
        logic [DVD_W-1:0] quo;
    } t_lane;

    // Four axes in order near x, near y, far x, far y.
    typedef t_lane [3:0] t_box;

endpackage

// ===== src/sbcb_div_cell.sv =====
`timescale 1ns / 1ps
// One restoring division step for all four axes: brings down the top dividend
// bit, subtracts the disparity when it fits and shifts in one quotient bit.
module sbcb_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  sbcb_pkg::t_box i_box,
    output logic          o_vld,
    output sbcb_pkg::t_box o_box
);

    logic           r_vld;
    sbcb_pkg::t_box r_box;
    sbcb_pkg::t_box n_box;

    always_comb begin
        logic [8:0] trial;
        for (int k = 0; k < 4; k++) begin
            trial = {i_box[k].rem, i_box[k].dvd[sbcb_pkg::DVD_W-1]};
            n_box[k]      = i_box[k];
            n_box[k].dvd  = {i_box[k].dvd[sbcb_pkg::DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, i_box[k].disp}) begin
                n_box[k].rem = 8'(trial - {1'b0, i_box[k].disp});
                n_box[k].quo = {i_box[k].quo[sbcb_pkg::DVD_W-2:0], 1'b1};
            end else begin
                n_box[k].rem = trial[7:0];
                n_box[k].quo = {i_box[k].quo[sbcb_pkg::DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_box <= n_box;
        end
    end

    assign o_vld = r_vld;
    assign o_box = r_box;

endmodule

// ===== src/stereo_box_corner_backprojection_unit.sv =====
`timescale 1ns / 1ps
// Back-projects both corners of a detection box to metric X/Y (signed Q16.16)
// as (pixel - center) * baseline / disparity, rounded to nearest with ties away
// from zero and saturated; the focal length cancels and has no effect. A box
// with a zero disparity at either corner yields no result. The block accepts
// one request per cycle unless the output stalls, and each request flows
// through these stages in order: one stage forms the pixel offsets, one multiplies by
// the baseline, a chain of 37 division cells produces one quotient bit each,
// and one output register applies saturation. The whole pipeline advances
// together and holds while a result waits, so ready is low only when the
// output register is full and not being taken.
module stereo_box_corner_backprojection_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_near_u,
    input  logic [15:0] i_near_v,
    input  logic [15:0] i_far_u,
    input  logic [15:0] i_far_v,
    input  logic [7:0]  i_near_disp,
    input  logic [7:0]  i_far_disp,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_near_x,
    output logic signed [31:0] o_near_y,
    output logic signed [31:0] o_far_x,
    output logic signed [31:0] o_far_y
);

    localparam int NCELL = sbcb_pkg::DVD_W;

    // Configuration registers. The focal length cancels out of every result,
    // so a write to it is taken and dropped.
    logic [23:0] r_baseline;
    logic [15:0] r_center_u;
    logic [15:0] r_center_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline <= 24'd7864;
            r_center_u <= 16'd5120;
            r_center_v <= 16'd3840;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sbcb_pkg::CFG_BASELINE: r_baseline <= i_cfg_data;
                sbcb_pkg::CFG_FOCAL:    ;
                sbcb_pkg::CFG_CENTER_U: r_center_u <= i_cfg_data[15:0];
                sbcb_pkg::CFG_CENTER_V: r_center_v <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves whenever the output register can take a result.
    logic en;
    logic r_valid;
    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    logic accept;
    logic keep;
    assign accept = i_valid && en;
    assign keep   = (i_near_disp != 8'd0) && (i_far_disp != 8'd0);

    // Stage one: signed pixel offsets as sign and magnitude.
    logic        r_s1_vld;
    logic [15:0] r_s1_mag [4];
    logic [3:0]  r_s1_neg;
    logic [7:0]  r_s1_disp [4];
    logic [15:0] pix [4];
    logic [15:0] ctr [4];

    assign pix[0] = i_near_u;
    assign pix[1] = i_near_v;
    assign pix[2] = i_far_u;
    assign pix[3] = i_far_v;
    assign ctr[0] = r_center_u;
    assign ctr[1] = r_center_v;
    assign ctr[2] = r_center_u;
    assign ctr[3] = r_center_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= accept && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_s1_neg[k]  <= pix[k] < ctr[k];
                r_s1_mag[k]  <= (pix[k] < ctr[k]) ? 16'(ctr[k] - pix[k])
                                                  : 16'(pix[k] - ctr[k]);
                r_s1_disp[k] <= (k < 2) ? i_near_disp : i_far_disp;
            end
        end
    end

    // Stage two: multiply by the baseline and add half the divisor for
    // rounding; the low four bits drop since the divisor is sixteen times
    // the disparity.
    logic           r_s2_vld;
    sbcb_pkg::t_box r_s2_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [40:0] num;
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                num = 41'(r_s1_mag[k] * r_baseline) + 41'({r_s1_disp[k], 3'b000});
                r_s2_box[k].neg  <= r_s1_neg[k];
                r_s2_box[k].disp <= r_s1_disp[k];
                r_s2_box[k].rem  <= 8'd0;
                r_s2_box[k].dvd  <= num[40:4];
                r_s2_box[k].quo  <= '0;
            end
        end
    end

    // Chain of division cells, one quotient bit per cell.
    logic           c_vld [NCELL+1];
    sbcb_pkg::t_box c_box [NCELL+1];

    assign c_vld[0] = r_s2_vld;
    assign c_box[0] = r_s2_box;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        sbcb_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (c_vld[g]),
            .i_box   (c_box[g]),
            .o_vld   (c_vld[g+1]),
            .o_box   (c_box[g+1])
        );
    end

    // Output register with sign restore and saturation.
    logic [31:0] r_out [4];
    logic [31:0] sat [4];

    always_comb begin
        logic [sbcb_pkg::DVD_W-1:0] q;
        for (int k = 0; k < 4; k++) begin
            q = c_box[NCELL][k].quo;
            if (c_box[NCELL][k].neg) begin
                sat[k] = (q >= 37'h0080000000) ? 32'h80000000 : 32'(32'd0 - q[31:0]);
            end else begin
                sat[k] = (q > 37'h007FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= c_vld[NCELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_out[k] <= sat[k];
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_near_x = r_out[0];
    assign o_near_y = r_out[1];
    assign o_far_x  = r_out[2];
    assign o_far_y  = r_out[3];

    // A request with a zero disparity never enters the pipeline.
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_near_disp == 8'd0 || i_far_disp == 8'd0)) |=> !r_s1_vld)
        else $error("dropped request entered the pipeline");

    // A stalled pipeline keeps the valid flags of stages one and two unchanged.
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_s1_vld) && $stable(r_s2_vld))
        else $error("pipeline moved while stalled");

    // The output sign follows the stored sign unless the magnitude is zero.
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && c_vld[NCELL] && !c_box[NCELL][0].neg) |=> !o_near_x[31])
        else $error("positive axis produced a negative result");

endmodule

// ===== dv/stereo_box_corner_backprojection_unit_test.sv =====
`timescale 1ns / 1ps
module stereo_box_corner_backprojection_unit_test;

    // PIPE_LAT is the pipeline depth from a taken request to its result. The drain
    // wait at the end is a little longer than that.
    localparam int PIPE_LAT   = 40;
    localparam int STALL_MAX  = 20000;

    typedef struct {
        logic signed [31:0] near_x;
        logic signed [31:0] near_y;
        logic signed [31:0] far_x;
        logic signed [31:0] far_y;
    } t_coords;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_near_u;
    logic [15:0] i_near_v;
    logic [15:0] i_far_u;
    logic [15:0] i_far_v;
    logic [7:0]  i_near_disp;
    logic [7:0]  i_far_disp;
    logic        o_valid;
    logic        i_ready;
    logic signed [31:0] o_near_x;
    logic signed [31:0] o_near_y;
    logic signed [31:0] o_far_x;
    logic signed [31:0] o_far_y;

    // The testbench keeps its own copy of the calibration registers. The
    // focal length cancels, so no copy of it is needed.
    logic [23:0] cal_baseline;
    logic [15:0] cal_cu;
    logic [15:0] cal_cv;

    t_coords pending_coords[$];
    int      error_count;
    int      idle_cycles;
    bit      timed_out;
    // Percent chance that the sink raises ready at each draw, set per test.
    int      sink_pct;

    stereo_box_corner_backprojection_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // A random gap: most are zero or short, a few are long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Back-projects one axis: (pix - center) * baseline / (16 * disp), rounded
    // to nearest with ties away from zero, then clamped to the Q16.16 range.
    function automatic logic signed [31:0] metric_axis(logic [15:0] pix,
                                                       logic [15:0] ctr,
                                                       logic [7:0] disp);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        neg = pix < ctr;
        mag = neg ? 64'(ctr - pix) : 64'(pix - ctr);
        num = mag * 64'(cal_baseline);
        den = 64'(disp) * 64'd16;
        q   = (num + den / 2) / den;
        if (neg) begin
            if (q >= 64'h8000_0000) return 32'sh8000_0000;
            return -$signed(32'(q));
        end
        if (q > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
        return $signed(32'(q));
    endfunction

    // Writes one calibration register. Called only while the block is idle.
    task automatic write_cal(logic [1:0] idx, logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            sbcb_pkg::CFG_BASELINE: cal_baseline = val;
            sbcb_pkg::CFG_FOCAL:    ;
            sbcb_pkg::CFG_CENTER_U: cal_cu       = val[15:0];
            sbcb_pkg::CFG_CENTER_V: cal_cv       = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_cal(logic [23:0] base, logic [15:0] foc,
                           logic [15:0] cu, logic [15:0] cv);
        write_cal(sbcb_pkg::CFG_BASELINE, base);
        write_cal(sbcb_pkg::CFG_FOCAL, {8'($urandom), foc});
        write_cal(sbcb_pkg::CFG_CENTER_U, {8'($urandom), cu});
        write_cal(sbcb_pkg::CFG_CENTER_V, {8'($urandom), cv});
    endtask

    // Waits until every expected result has come back, then lets the
    // pipeline run empty.
    task automatic drain();
        while (pending_coords.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    // Sends one box request and records the coordinates it should produce.
    task automatic send_box(logic [15:0] nu, logic [15:0] nv, logic [15:0] fu,
                            logic [15:0] fv, logic [7:0] nd, logic [7:0] fd);
        t_coords c;
        int      g;
        // With no gap the next request follows the previous one at once and
        // valid stays high; otherwise valid drops for the length of the gap.
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_near_u    <= nu;
        i_near_v    <= nv;
        i_far_u     <= fu;
        i_far_v     <= fv;
        i_near_disp <= nd;
        i_far_disp  <= fd;
        do @(posedge i_clk); while (!o_ready && !timed_out);
        // The request is taken at this edge. A zero disparity drops the box.
        if (nd != 0 && fd != 0) begin
            c.near_x = metric_axis(nu, cal_cu, nd);
            c.near_y = metric_axis(nv, cal_cv, nd);
            c.far_x  = metric_axis(fu, cal_cu, fd);
            c.far_y  = metric_axis(fv, cal_cv, fd);
            pending_coords.insert(pending_coords.size(), c);
        end
    endtask

    // Lowers valid right at the edge that took the last request.
    task automatic end_burst();
        i_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_disp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 8'd0;
        if (r < 10) return 8'd255;
        if (r < 16) return 8'd1;
        return 8'($urandom_range(1, 255));
    endfunction

    // Pixel values: mostly near the center, sometimes anywhere in range.
    function automatic logic [15:0] rand_pix(logic [15:0] ctr);
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return ctr + 16'($signed($urandom_range(0, 8191)) - 4096);
    endfunction

    task automatic test_reset_calibration();
        sink_pct = 100;
        send_box(16'd5120, 16'd3840, 16'd5121, 16'd3839, 8'd1, 8'd1);
        send_box(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 8'd255, 8'd1);
        send_box(16'd1000, 16'd2000, 16'd7000, 16'd6000, 8'd17, 8'd64);
        end_burst();
        drain();
    endtask

    task automatic test_invalid_disparity();
        sink_pct = 70;
        send_box(16'd100, 16'd200, 16'd300, 16'd400, 8'd0, 8'd10);
        send_box(16'd100, 16'd200, 16'd300, 16'd400, 8'd10, 8'd0);
        send_box(16'd100, 16'd200, 16'd300, 16'd400, 8'd0, 8'd0);
        send_box(16'd100, 16'd200, 16'd300, 16'd400, 8'd10, 8'd10);
        end_burst();
        drain();
    endtask

    task automatic test_saturation();
        // A full baseline and a one pixel disparity push every axis of the first
        // box past the Q16.16 range in both directions.
        set_cal(24'hFFFFFF, 16'hFFFF, 16'h8000, 16'h8000);
        sink_pct = 50;
        send_box(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 8'd1, 8'd1);
        send_box(16'hFFFF, 16'd0, 16'h8001, 16'h7FFF, 8'd255, 8'd2);
        send_box(16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'd3, 8'd3);
        end_burst();
        drain();
        // Zero baseline maps everything to the origin; centers at both ends.
        set_cal(24'd0, 16'd1, 16'd0, 16'hFFFF);
        send_box(16'hFFFF, 16'd0, 16'd1234, 16'd4321, 8'd1, 8'd200);
        end_burst();
        drain();
        // Ties: baseline 8 with disparity 1 gives offsets of exactly one half.
        set_cal(24'd8, 16'd1, 16'd100, 16'd100);
        send_box(16'd101, 16'd99, 16'd103, 16'd97, 8'd1, 8'd1);
        send_box(16'd101, 16'd99, 16'd103, 16'd97, 8'd3, 8'd5);
        end_burst();
        drain();
    endtask

    task automatic test_random_boxes();
        for (int phase = 0; phase < 4 && !timed_out; phase++) begin
            case (phase)
                0: set_cal(24'd7864, 16'd11200, 16'd5120, 16'd3840);
                1: set_cal(24'($urandom), 16'($urandom_range(1, 65535)),
                           16'($urandom), 16'($urandom));
                2: set_cal(24'hFFFFFF, 16'd1, 16'd0, 16'd0);
                default: set_cal(24'($urandom_range(1, 65535)), 16'hFFFF,
                                 16'hFFFF, 16'hFFFF);
            endcase
            sink_pct = (phase == 1) ? 100 : $urandom_range(30, 90);
            for (int n = 0; n < 250 && !timed_out; n++)
                send_box(rand_pix(cal_cu), rand_pix(cal_cv), rand_pix(cal_cu),
                         rand_pix(cal_cv), rand_disp(), rand_disp());
            end_burst();
            drain();
        end
    endtask

    // The sink takes results with random stalls, long ones now and then.
    initial begin
        int g;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 99) < sink_pct) begin
                i_ready <= 1'b1;
            end else begin
                g = gap_len();
                i_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    // Every result is checked against the oldest expected coordinates.
    always @(posedge i_clk) begin
        t_coords c;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_coords.size() == 0) begin
                $display("%0t: result with nothing expected: %h %h %h %h", $time,
                         o_near_x, o_near_y, o_far_x, o_far_y);
                error_count++;
            end else begin
                c = pending_coords.pop_front();
                if (o_near_x !== c.near_x) begin
                    $display("%0t: near_x expected %0d actual %0d", $time,
                             c.near_x, o_near_x);
                    error_count++;
                end
                if (o_near_y !== c.near_y) begin
                    $display("%0t: near_y expected %0d actual %0d", $time,
                             c.near_y, o_near_y);
                    error_count++;
                end
                if (o_far_x !== c.far_x) begin
                    $display("%0t: far_x expected %0d actual %0d", $time,
                             c.far_x, o_far_x);
                    error_count++;
                end
                if (o_far_y !== c.far_y) begin
                    $display("%0t: far_y expected %0d actual %0d", $time,
                             c.far_y, o_far_y);
                    error_count++;
                end
            end
        end
    end

    // The watchdog counts cycles in which neither side takes anything.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX && !timed_out) begin
            timed_out = 1'b1;
            $display("stereo_box_corner_backprojection_unit_test: done, errors");
            $finish;
        end
    end

    initial begin
        error_count  = 0;
        idle_cycles  = 0;
        timed_out    = 1'b0;
        sink_pct     = 100;
        cal_baseline = 24'd7864;
        cal_cu       = 16'd5120;
        cal_cv       = 16'd3840;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = sbcb_pkg::CFG_BASELINE;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_near_u     = '0;
        i_near_v     = '0;
        i_far_u      = '0;
        i_far_v      = '0;
        i_near_disp  = '0;
        i_far_disp   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_calibration();
        test_invalid_disparity();
        test_saturation();
        test_random_boxes();

        if (error_count == 0 && pending_coords.size() == 0)
            $display("stereo_box_corner_backprojection_unit_test: done, clean");
        else
            $display("stereo_box_corner_backprojection_unit_test: done, errors");
        $finish;
    end

endmodule
